[design/sdf_pkg.sv]
// Shared constants and controller/datapath interface types for the
// signed decimal field formatter. No dependencies.
`default_nettype none

package sdf_pkg;

   // sizing
   localparam int MAX_CHARS  = 64;
   localparam int VALUE_BITS = 32;
   localparam int DIGITS     = 10;   // decimal digits of a 32-bit magnitude
   localparam int CNT_BITS   = 7;    // holds 0..MAX_CHARS
   localparam int DIG_BITS   = 4;    // holds 0..DIGITS
   localparam int POS_BITS   = 6;

   // input item fields
   localparam int FLAGS_BITS = 5;
   localparam int WIDTH_BITS = 7;
   localparam int PREC_BITS  = 6;
   localparam int LIMIT_BITS = 7;
   localparam int REQ_BITS   = 64;
   localparam int RSP_BITS   = 16;

   // format flag bit positions
   localparam int FLAG_LEFT  = 0;
   localparam int FLAG_ZERO  = 1;
   localparam int FLAG_PLUS  = 2;
   localparam int FLAG_SPACE = 3;
   localparam int FLAG_PREC  = 4;

   // characters
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;

   // reciprocal of ten: q = (n * RECIP_TEN) >> RECIP_SHIFT, exact for 32-bit n
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture a new input item
      logic step;    // produce one decimal digit
      logic setup;   // work out the text layout
      logic emit;    // load the next character into the output register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic conv_done;   // the digit being produced now is the last one
      logic count_zero;  // no characters to emit
      logic emit_last;   // the character being loaded is the final one
   } dp_status_type;

endpackage

`default_nettype wire

[design/sdf_datapath.sv]
// Datapath: input capture, digit conversion by reciprocal multiply,
// layout setup and character generation. Depends on sdf_pkg.
`default_nettype none

module sdf_datapath (
   input  wire                      clock,
   input  wire                      reset,
   input  sdf_pkg::dp_cmd_type      cmd,
   output sdf_pkg::dp_status_type   status,
   input  wire [63:0]               req_data,
   output logic [15:0]              rsp_data,
   output logic                     rsp_last
);
   import sdf_pkg::*;

   // captured format
   logic [VALUE_BITS-1:0]  mag_ff, mag_in;
   logic [FLAGS_BITS-1:0]  flags_ff;
   logic [WIDTH_BITS-1:0]  width_ff;
   logic [PREC_BITS-1:0]   prec_ff;
   logic [LIMIT_BITS-1:0]  limit_ff;
   logic                   neg_ff;
   logic                   val_zero_ff;

   // digit store, least significant first
   logic [3:0]             digit_ff [DIGITS];
   logic [DIG_BITS-1:0]    ndig_raw_ff;

   // layout
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [CNT_BITS-1:0]    dig_start_ff, dig_start_in;
   logic [CNT_BITS-1:0]    dig_end_ff, dig_end_in;
   logic [CNT_BITS-1:0]    sign_pos_ff, sign_pos_in;
   logic [7:0]             sign_sym_ff, sign_sym_in;
   logic                   has_sign_ff, has_sign_in;
   logic [7:0]             fill_char_ff, fill_char_in;
   logic [CNT_BITS-1:0]    pos_ff;

   // output register
   logic [7:0]             out_char_ff, out_char_in;
   logic [POS_BITS-1:0]    out_pos_ff;
   logic                   out_last_ff;

   // input field slices
   logic [VALUE_BITS-1:0]  raw_value;
   logic                   raw_neg;
   assign raw_value = req_data[31:0];
   assign raw_neg   = raw_value[VALUE_BITS-1];

   always_comb begin
      mag_in = raw_neg ? (~raw_value + 32'd1) : raw_value;
   end

   // one decimal digit per step
   logic [63:0]            product;
   logic [VALUE_BITS-1:0]  quot;
   logic [VALUE_BITS-1:0]  quot_x10;
   logic [VALUE_BITS-1:0]  remainder;
   assign product   = 64'(mag_ff) * 64'(RECIP_TEN);
   assign quot      = 32'(product[63:RECIP_SHIFT]);
   assign quot_x10  = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
   assign remainder = mag_ff - quot_x10;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff      <= mag_in;
         neg_ff      <= raw_neg;
         val_zero_ff <= (raw_value == '0);
         flags_ff    <= req_data[36:32];
         width_ff    <= req_data[43:37];
         prec_ff     <= req_data[49:44];
         limit_ff    <= req_data[56:50];
         ndig_raw_ff <= '0;
      end else if (cmd.step) begin
         mag_ff                <= quot;
         digit_ff[ndig_raw_ff] <= remainder[3:0];
         ndig_raw_ff           <= ndig_raw_ff + DIG_BITS'(1);
      end
   end

   assign status.conv_done = (mag_ff < VALUE_BITS'(10));

   // layout of the text
   logic [CNT_BITS-1:0] ndig, ndig_s, width_sat, limit_sat, pad, total;
   logic                left_mode, zero_mode, right_mode;

   always_comb begin
      left_mode  = flags_ff[FLAG_LEFT];
      zero_mode  = !left_mode && flags_ff[FLAG_ZERO] && !flags_ff[FLAG_PREC];
      right_mode = !left_mode && !zero_mode;

      if (neg_ff) begin
         sign_sym_in = CHAR_MINUS;
         has_sign_in = 1'b1;
      end else if (flags_ff[FLAG_PLUS]) begin
         sign_sym_in = CHAR_PLUS;
         has_sign_in = 1'b1;
      end else if (flags_ff[FLAG_SPACE]) begin
         sign_sym_in = CHAR_SPACE;
         has_sign_in = 1'b1;
      end else begin
         sign_sym_in = CHAR_SPACE;
         has_sign_in = 1'b0;
      end

      // digit count: zero with precision zero prints nothing
      if (val_zero_ff && flags_ff[FLAG_PREC] && (prec_ff == '0))
         ndig = '0;
      else
         ndig = CNT_BITS'(ndig_raw_ff);
      if (flags_ff[FLAG_PREC] && (ndig < CNT_BITS'(prec_ff)))
         ndig = CNT_BITS'(prec_ff);

      ndig_s    = ndig + CNT_BITS'(has_sign_in);
      width_sat = (width_ff > CNT_BITS'(MAX_CHARS)) ? CNT_BITS'(MAX_CHARS) : width_ff;
      limit_sat = (limit_ff > CNT_BITS'(MAX_CHARS)) ? CNT_BITS'(MAX_CHARS) : limit_ff;
      pad       = (width_sat > ndig_s) ? (width_sat - ndig_s) : '0;
      total     = ndig_s + pad;
      count_in  = (total < limit_sat) ? total : limit_sat;

      dig_end_in   = left_mode ? ndig_s : total;
      dig_start_in = dig_end_in - ndig;
      sign_pos_in  = right_mode ? pad : '0;
      fill_char_in = zero_mode ? CHAR_ZERO : CHAR_SPACE;
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         count_ff     <= count_in;
         dig_start_ff <= dig_start_in;
         dig_end_ff   <= dig_end_in;
         sign_pos_ff  <= sign_pos_in;
         sign_sym_ff  <= sign_sym_in;
         has_sign_ff  <= has_sign_in;
         fill_char_ff <= fill_char_in;
      end
   end

   assign status.count_zero = (count_ff == '0);
   assign status.emit_last  = ((pos_ff + CNT_BITS'(1)) == count_ff);

   // character at the current position
   logic [CNT_BITS-1:0] dig_idx;
   logic [3:0]          dig_val;
   always_comb begin
      dig_idx = dig_end_ff - CNT_BITS'(1) - pos_ff;
      if (dig_idx < CNT_BITS'(ndig_raw_ff))
         dig_val = digit_ff[dig_idx[DIG_BITS-1:0]];
      else
         dig_val = 4'd0;

      if ((pos_ff >= dig_start_ff) && (pos_ff < dig_end_ff))
         out_char_in = CHAR_ZERO | {4'd0, dig_val};
      else if (has_sign_ff && (pos_ff == sign_pos_ff))
         out_char_in = sign_sym_ff;
      else
         out_char_in = fill_char_ff;
   end

   // position counter and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (cmd.setup) begin
         pos_ff <= '0;
      end else if (cmd.emit) begin
         pos_ff <= pos_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_char_ff <= out_char_in;
         out_pos_ff  <= pos_ff[POS_BITS-1:0];
         out_last_ff <= status.emit_last;
      end
   end

   assign rsp_data = {2'b00, out_pos_ff, out_char_ff};
   assign rsp_last = out_last_ff;

endmodule

`default_nettype wire

[design/sdf_ctrl.sv]
// Controller: sequences capture, conversion, setup and emission, and owns
// the handshake flags. Depends on sdf_pkg.
`default_nettype none

module sdf_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output sdf_pkg::dp_cmd_type      cmd,
   input  sdf_pkg::dp_status_type   status
);
   import sdf_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CONV  = 2'd1;
   localparam logic [1:0] ST_SETUP = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_free;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            if (status.conv_done)
               state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.count_zero) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last)
                  state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register occupancy
   always_comb begin
      if (cmd.emit)
         out_valid_in = 1'b1;
      else if (rsp_tready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

[design/signed_decimal_field_formatter_unit.sv]
// Top level of the signed decimal field formatter: joins controller and
// datapath. Depends on sdf_pkg, sdf_ctrl and sdf_datapath.
//
// Use: one request item carries a signed integer and its %d format; the
// block answers with the formatted text, one ASCII character per response
// item, tagged with its position, and rsp_tlast on the final character sent.
// An item whose text is empty or whose output limit is zero yields nothing.
// Steps per item: a capture step, one divide-by-ten multiplier step per
// decimal digit of the magnitude (1 to 10 digits), a layout step, then one
// character per cycle while the receiver takes them. req_tready is high
// only while no item is in work; the next item may be taken while the last
// character still sits in the output register.
// A receiver stall holds the output register and its character; emission
// waits and no character is lost. Reset returns the controller to idle and
// drops rsp_tvalid; no clearing pass is needed.
`default_nettype none

module signed_decimal_field_formatter_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // value[31:0], format_flags[36:32], field_width[43:37],
   // min_digits[49:44], output_limit[56:50], zeros above
   input  wire  [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // character[7:0], position[13:8], zeros above
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast
);
   import sdf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   sdf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   sdf_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_tdata),
      .rsp_data (rsp_tdata),
      .rsp_last (rsp_tlast)
   );

endmodule

`default_nettype wire
